// ===== src/sdf_text_pixel_blend_unit_macros.svh =====
// Assertion macros used by the checker file of the SDF text pixel blend unit.
// Depends on nothing; included by bare file name.
`ifndef SDF_TEXT_PIXEL_BLEND_UNIT_MACROS_SVH
`define SDF_TEXT_PIXEL_BLEND_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STPB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("stpb assertion failed");

// Condition must never be seen outside reset.
`define STPB_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("stpb forbidden condition seen");

`endif

// ===== src/stpb_pkg.sv =====
// Shared types, constants and the gamma encode function of the SDF text pixel blend unit.
// Depends on nothing.
package stpb_pkg;

	localparam int QueueDepth = 8;
	localparam int QPtrW = $clog2(QueueDepth);
	localparam int QCntW = $clog2(QueueDepth + 1);
	localparam int InflightW = 2;

	localparam logic [2:0] RegBand  = 3'd0;
	localparam logic [2:0] RegBias  = 3'd1;
	localparam logic [2:0] RegRed   = 3'd2;
	localparam logic [2:0] RegGreen = 3'd3;
	localparam logic [2:0] RegBlue  = 3'd4;
	localparam logic [2:0] RegAlpha = 3'd5;

	localparam logic [15:0] BandMin = 16'd256;
	localparam logic [6:0] BiasMax = 7'd115;
	localparam logic [8:0] CovFull = 9'd256;

	typedef struct packed {
		logic [8:0] cov;
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
	} blend_item_t;

	typedef struct packed {
		logic empty;
		logic [QCntW-1:0] count;
	} queue_status_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} text_color_t;

	// Rounded square root of 255 * c, digit by digit over eight steps.
	function automatic logic [7:0] gamma_encode(input logic [7:0] c);
		logic [15:0] x;
		logic [17:0] rem;
		logic [17:0] trial;
		logic [7:0] root;
		x = {c, 8'h00} - {8'h00, c};
		rem = '0;
		root = '0;
		for (int i = 7; i >= 0; i--) begin
			rem = {rem[15:0], x[2*i +: 2]};
			trial = {8'h00, root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[6:0], 1'b1};
			end else begin
				root = {root[6:0], 1'b0};
			end
		end
		if (rem > {10'd0, root}) begin
			root = root + 8'd1;
		end
		return root;
	endfunction

endpackage

// ===== src/stpb_front.sv =====
// Front end: bilinear distance sample, band scaling and coverage, one pixel per cycle.
// Depends on stpb_pkg.
module stpb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  texel_top_left,
	input  logic [7:0]                  texel_top_right,
	input  logic [7:0]                  texel_bottom_left,
	input  logic [7:0]                  texel_bottom_right,
	input  logic [7:0]                  frac_u,
	input  logic [7:0]                  frac_v,
	input  logic [7:0]                  dest_red,
	input  logic [7:0]                  dest_green,
	input  logic [7:0]                  dest_blue,
	input  logic [15:0]                 band_px,
	input  logic [6:0]                  stroke_bias,
	output logic                        push,
	output stpb_pkg::blend_item_t       push_item,
	output logic [stpb_pkg::InflightW-1:0] inflight
);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [17:0] top_s1, bot_s1;
	logic [7:0]         frac_v_s1;
	logic [23:0]        dest_s1, dest_s2, dest_s3;
	logic signed [24:0] dist_s2;
	logic signed [41:0] prod_s3;

	logic signed [8:0]  diff_top, diff_bot;
	logic signed [17:0] top_c, bot_c, row_diff;
	logic signed [26:0] vert_prod, samp, dist_c;
	logic [15:0]        band_c;
	logic [6:0]         bias_c;
	logic signed [42:0] t4;
	logic [42:0]        t4_round;
	logic [19:0]        r4;
	logic [8:0]         cov4;

	assign band_c = (band_px < stpb_pkg::BandMin) ? stpb_pkg::BandMin : band_px;
	assign bias_c = (stroke_bias > stpb_pkg::BiasMax) ? stpb_pkg::BiasMax : stroke_bias;

	always_comb begin
		diff_top = $signed({1'b0, texel_top_right}) - $signed({1'b0, texel_top_left});
		diff_bot = $signed({1'b0, texel_bottom_right}) - $signed({1'b0, texel_bottom_left});
		top_c = $signed({2'b00, texel_top_left, 8'h00}) + diff_top * $signed({1'b0, frac_u});
		bot_c = $signed({2'b00, texel_bottom_left, 8'h00}) + diff_bot * $signed({1'b0, frac_u});
	end

	always_comb begin
		row_diff = bot_s1 - top_s1;
		vert_prod = row_diff * $signed({1'b0, frac_v_s1});
		samp = $signed({top_s1[17], top_s1, 8'h00}) + vert_prod;
		dist_c = samp - 27'sd8388608;
	end

	always_comb begin
		t4 = $signed({prod_s3[41], prod_s3}) + 43'sd1073741824
			+ $signed({13'd0, bias_c, 23'd0});
		t4_round = t4 + 43'sd4194304;
		r4 = t4_round[42:23];
		if (t4 <= 43'sd0) begin
			cov4 = '0;
		end else if (r4 > 20'd256) begin
			cov4 = stpb_pkg::CovFull;
		end else begin
			cov4 = r4[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		top_s1 <= top_c;
		bot_s1 <= bot_c;
		frac_v_s1 <= frac_v;
		dest_s1 <= {dest_red, dest_green, dest_blue};
		dist_s2 <= dist_c[24:0];
		dest_s2 <= dest_s1;
		prod_s3 <= dist_s2 * $signed({1'b0, band_c});
		dest_s3 <= dest_s2;
	end

	assign push = valid_s3;
	assign push_item = '{cov: cov4, dest_red: dest_s3[23:16],
		dest_green: dest_s3[15:8], dest_blue: dest_s3[7:0]};
	assign inflight = {1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3};

endmodule

// ===== src/stpb_queue.sv =====
// Short queue between the coverage front end and the blend back end, registered read.
// Depends on stpb_pkg.
module stpb_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  stpb_pkg::blend_item_t   push_item,
	input  logic                    pop,
	output logic                    rd_valid,
	output stpb_pkg::blend_item_t   rd_item,
	output stpb_pkg::queue_status_t status
);

	stpb_pkg::blend_item_t mem_q [stpb_pkg::QueueDepth];
	logic [stpb_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [stpb_pkg::QCntW-1:0] count_q;
	logic                       rd_valid_q;
	stpb_pkg::blend_item_t      rd_item_q;
	logic                       do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
		if (do_pop) begin
			rd_item_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{(stpb_pkg::QCntW-1){1'b0}}, push}
				- {{(stpb_pkg::QCntW-1){1'b0}}, do_pop};
			rd_valid_q <= do_pop;
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_item = rd_item_q;
	assign status = '{empty: (count_q == '0), count: count_q};

endmodule

// ===== src/stpb_back.sv =====
// Back end: gamma encode of the text color, alpha blend and rounding, result registers.
// Depends on stpb_pkg.
module stpb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stpb_pkg::queue_status_t status,
	input  logic                    rd_valid,
	input  stpb_pkg::blend_item_t   rd_item,
	input  stpb_pkg::text_color_t   color,
	output logic                    pop,
	output logic                    done,
	output logic [7:0]              out_red,
	output logic [7:0]              out_green,
	output logic [7:0]              out_blue,
	output logic [8:0]              coverage_level,
	output logic                    pixel_written
);

	// Rounded division by 65280 of dest * 65280 + (g - dest) * a + 32640.
	function automatic logic [7:0] blend_div(input logic [7:0] dest,
		input logic signed [25:0] prod);
		logic signed [25:0] num;
		logic [15:0]        m;
		logic [16:0]        q;
		num = $signed({2'b00, dest, 16'h0000}) - $signed({10'd0, dest, 8'h00})
			+ prod + 26'sd32640;
		m = num[23:8];
		q = {1'b0, m} + {9'd0, m[15:8]} + 17'd1;
		return (q[16:8] > 9'd255) ? 8'hFF : q[15:8];
	endfunction

	logic [7:0]            g_red_q, g_green_q, g_blue_q;
	logic                  valid_b1, valid_b2;
	logic [16:0]           alpha_b1;
	stpb_pkg::blend_item_t item_b1, item_b2;
	logic signed [25:0]    prod_red_b2, prod_green_b2, prod_blue_b2;
	logic [7:0]            res_red, res_green, res_blue;
	logic                  done_q, written_q;
	logic [7:0]            out_red_q, out_green_q, out_blue_q;
	logic [8:0]            cov_q;

	assign pop = !status.empty;

	always_ff @(posedge clk) begin
		g_red_q <= stpb_pkg::gamma_encode(color.red);
		g_green_q <= stpb_pkg::gamma_encode(color.green);
		g_blue_q <= stpb_pkg::gamma_encode(color.blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_b1 <= rd_valid;
			valid_b2 <= valid_b1;
			done_q <= valid_b2;
		end
	end

	always_ff @(posedge clk) begin
		alpha_b1 <= color.alpha * rd_item.cov;
		item_b1 <= rd_item;
		prod_red_b2 <= ($signed({1'b0, g_red_q}) - $signed({1'b0, item_b1.dest_red}))
			* $signed({1'b0, alpha_b1});
		prod_green_b2 <= ($signed({1'b0, g_green_q}) - $signed({1'b0, item_b1.dest_green}))
			* $signed({1'b0, alpha_b1});
		prod_blue_b2 <= ($signed({1'b0, g_blue_q}) - $signed({1'b0, item_b1.dest_blue}))
			* $signed({1'b0, alpha_b1});
		item_b2 <= item_b1;
	end

	always_comb begin
		if (item_b2.cov == '0) begin
			res_red = item_b2.dest_red;
			res_green = item_b2.dest_green;
			res_blue = item_b2.dest_blue;
		end else begin
			res_red = blend_div(item_b2.dest_red, prod_red_b2);
			res_green = blend_div(item_b2.dest_green, prod_green_b2);
			res_blue = blend_div(item_b2.dest_blue, prod_blue_b2);
		end
	end

	always_ff @(posedge clk) begin
		out_red_q <= res_red;
		out_green_q <= res_green;
		out_blue_q <= res_blue;
		cov_q <= item_b2.cov;
		written_q <= (item_b2.cov != '0) && ((res_red != item_b2.dest_red)
			|| (res_green != item_b2.dest_green) || (res_blue != item_b2.dest_blue));
	end

	assign done = done_q;
	assign out_red = out_red_q;
	assign out_green = out_green_q;
	assign out_blue = out_blue_q;
	assign coverage_level = cov_q;
	assign pixel_written = written_q;

endmodule

// ===== src/sdf_text_pixel_blend_unit.sv =====
// SDF text pixel blend unit: takes one pixel per clock while busy is low; the result strobe done
// follows the front stages, the queue, its read register and the back stages, and stays high one cycle.
// The front end, the queue read and the back end each run one pixel per cycle, so the
// queue never fills and busy stays low; busy tracks queue occupancy plus front stages.
// Reset clears all pipeline valids and the queue and loads the register defaults.
module sdf_text_pixel_blend_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  texel_top_left,
	input  logic [7:0]  texel_top_right,
	input  logic [7:0]  texel_bottom_left,
	input  logic [7:0]  texel_bottom_right,
	input  logic [7:0]  frac_u,
	input  logic [7:0]  frac_v,
	input  logic [7:0]  dest_red,
	input  logic [7:0]  dest_green,
	input  logic [7:0]  dest_blue,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [8:0]  coverage_level,
	output logic        pixel_written
);

	logic [15:0]                   band_q;
	logic [6:0]                    bias_q;
	stpb_pkg::text_color_t         color_q;
	logic                          accept;
	logic                          push, pop, rd_valid;
	stpb_pkg::blend_item_t         push_item, rd_item;
	stpb_pkg::queue_status_t       status;
	logic [stpb_pkg::InflightW-1:0] inflight;
	logic [stpb_pkg::QCntW:0]      occupancy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= 16'd256;
			bias_q <= 7'd0;
			color_q <= '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF};
		end else if (cfg_write) begin
			unique case (cfg_index)
				stpb_pkg::RegBand: band_q <= cfg_data;
				stpb_pkg::RegBias: bias_q <= cfg_data[6:0];
				stpb_pkg::RegRed: color_q.red <= cfg_data[7:0];
				stpb_pkg::RegGreen: color_q.green <= cfg_data[7:0];
				stpb_pkg::RegBlue: color_q.blue <= cfg_data[7:0];
				stpb_pkg::RegAlpha: color_q.alpha <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign occupancy = {1'b0, status.count}
		+ {{(stpb_pkg::QCntW + 1 - stpb_pkg::InflightW){1'b0}}, inflight};
	assign busy = (occupancy >= (stpb_pkg::QCntW + 1)'(stpb_pkg::QueueDepth));
	assign accept = start && !busy;

	stpb_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.texel_top_left     (texel_top_left),
		.texel_top_right    (texel_top_right),
		.texel_bottom_left  (texel_bottom_left),
		.texel_bottom_right (texel_bottom_right),
		.frac_u             (frac_u),
		.frac_v             (frac_v),
		.dest_red           (dest_red),
		.dest_green         (dest_green),
		.dest_blue          (dest_blue),
		.band_px            (band_q),
		.stroke_bias        (bias_q),
		.push               (push),
		.push_item          (push_item),
		.inflight           (inflight)
	);

	stpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.rd_valid  (rd_valid),
		.rd_item   (rd_item),
		.status    (status)
	);

	stpb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.status         (status),
		.rd_valid       (rd_valid),
		.rd_item        (rd_item),
		.color          (color_q),
		.pop            (pop),
		.done           (done),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.coverage_level (coverage_level),
		.pixel_written  (pixel_written)
	);

endmodule

// ===== src/stpb_checker.sv =====
// Port-level checker for the SDF text pixel blend unit, bound to the top level.
// Depends on sdf_text_pixel_blend_unit_macros.svh.
`include "sdf_text_pixel_blend_unit_macros.svh"

module stpb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [8:0]  coverage_level,
	input logic        pixel_written
);

	`STPB_ASSERT(a_transfer_gives_result, clk, arst_n, (start && !busy) |-> ##8 done)
	`STPB_ASSERT(a_result_has_transfer, clk, arst_n, done |-> $past(start && !busy, 8))
	`STPB_NEVER(a_no_write_at_zero_cov, clk, arst_n, done && (coverage_level == 9'd0) && pixel_written)
	`STPB_NEVER(a_cov_in_range, clk, arst_n, done && (coverage_level > 9'd256))

endmodule

bind sdf_text_pixel_blend_unit stpb_checker u_stpb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.coverage_level (coverage_level),
	.pixel_written  (pixel_written)
);
